### src/lrk4_pkg.sv
// Package for the Lorenz RK4 integrator: payload types, register indexes,
// widths, the default fraction width and datapath command types. No dependencies.
package lrk4_pkg;

  localparam int FracBitsDef = 24;
  localparam int CfgW = 31;
  localparam int CfgIdxW = 2;
  localparam int DtW = 25;

  localparam logic [CfgIdxW-1:0] REG_SIGMA = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_RHO   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_BETA  = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_DT    = 2'd3;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef struct packed {
    logic               cmd;
    logic signed [31:0] start_x;
    logic signed [31:0] start_y;
    logic signed [31:0] start_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic               saturated;
  } out_item_t;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_INIT, OP_D0, OP_D1, OP_D2, OP_D3, OP_D4,
    OP_OFS, OP_ACC, OP_FIN0, OP_FIN1, OP_FIN2
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] stage;  // which k is being computed (0..3), or the coordinate when finishing
  } dp_cmd_t;

endpackage

### src/lorenz_rk4_integrator.sv
// Top level of the Lorenz RK4 integrator: configuration registers,
// sequencer and datapath. Uses lrk4_pkg, lrk4_ctrl and lrk4_datapath.
//
// A load transaction sets the point at the accepting edge and offers it in the
// next cycle. A step transaction takes one setup state, four derivative passes
// on one set of multipliers (states D0 to D4, ACC and OFS each, the last pass
// without OFS, as it needs no new offset point), then three states per
// coordinate that scale the weighted sum by the time step and divide it by six.
// One transaction is in work at a time; the result is held until the receiver
// takes it, and the input is taken again once the sequencer is back in idle.
module lorenz_rk4_integrator
  import lrk4_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_item_t           in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output out_item_t          out_item,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [CfgW-1:0]    cfg_data
);

  localparam logic [63:0] CfgMax = (64'd1 << CfgW) - 64'd1;
  localparam logic [63:0] DtMax = (64'd1 << DtW) - 64'd1;
  localparam logic [63:0] SigmaRaw = 64'd10 << FRAC_BITS;
  localparam logic [63:0] RhoRaw = 64'd28 << FRAC_BITS;
  localparam logic [63:0] BetaRaw = ((64'd8 << FRAC_BITS) + 64'd1) / 64'd3;
  localparam logic [63:0] DtRaw = ((64'd5 << FRAC_BITS) + 64'd500) / 64'd1000;
  localparam logic [CfgW-1:0] SigmaDef = CfgW'((SigmaRaw > CfgMax) ? CfgMax : SigmaRaw);
  localparam logic [CfgW-1:0] RhoDef = CfgW'((RhoRaw > CfgMax) ? CfgMax : RhoRaw);
  localparam logic [CfgW-1:0] BetaDef = CfgW'((BetaRaw > CfgMax) ? CfgMax : BetaRaw);
  localparam logic [DtW-1:0]  DtDef = DtW'((DtRaw > DtMax) ? DtMax : DtRaw);

  logic [CfgW-1:0] sigma_r, rho_r, beta_r;
  logic [DtW-1:0]  dt_r;
  dp_cmd_t         cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r <= SigmaDef;
      rho_r   <= RhoDef;
      beta_r  <= BetaDef;
      dt_r    <= DtDef;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIGMA: sigma_r <= cfg_data;
        REG_RHO:   rho_r <= cfg_data;
        REG_BETA:  beta_r <= cfg_data;
        REG_DT:    dt_r <= cfg_data[DtW-1:0];
        default: ;
      endcase
    end
  end

  lrk4_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_cmd(in_item.cmd),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd)
  );

  lrk4_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .sigma(sigma_r), .rho(rho_r), .beta(beta_r), .dt(dt_r),
    .item(in_item), .cmd(cmd), .result(out_item)
  );

endmodule

### src/lrk4_datapath.sv
// Datapath of the Lorenz RK4 integrator: point, work registers, a set of 64-bit
// multipliers shared by all passes and the final scaling by dt/6. Uses lrk4_pkg.
module lrk4_datapath
  import lrk4_pkg::*;
#(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [CfgW-1:0]    sigma,
  input  logic [CfgW-1:0]    rho,
  input  logic [CfgW-1:0]    beta,
  input  logic [DtW-1:0]     dt,
  input  in_item_t           item,
  input  dp_cmd_t            cmd,
  output out_item_t          result
);

  localparam logic signed [63:0] S32MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32MIN = -64'sd2147483648;
  // The scaled sum is below 2^43 in magnitude; it is divided by 3 in two 22-bit halves.
  localparam int DivW = 44;
  localparam int HalfW = 22;
  // floor(x * RECIP3 / 2^33) equals floor(x / 3) for any x below 2^32.
  localparam logic [63:0] RECIP3 = 64'h0000_0000_AAAA_AAAB;

  logic signed [31:0] p_r [3];
  logic signed [31:0] q_r [3];
  logic signed [31:0] k_r [3];
  logic signed [34:0] acc_r [3];
  logic signed [31:0] t_r [4];
  logic               sat_r;
  logic [DivW-1:0]    u_r;
  logic               neg_r;
  logic [HalfW-1:0]   qh_r;
  logic [1:0]         rh_r;

  function automatic logic signed [63:0] fshift(input logic signed [63:0] v, input int s);
    fshift = v >>> s;
  endfunction

  // Clamp to 32 bits signed; flag reports whether clamping happened.
  function automatic logic signed [32:0] clamp(input logic signed [63:0] v);
    if (v > S32MAX) clamp = {1'b1, 32'sh7fffffff};
    else if (v < S32MIN) clamp = {1'b1, 32'sh80000000};
    else clamp = {1'b0, v[31:0]};
  endfunction

  logic signed [63:0] m0, m1, m2;
  logic signed [32:0] c0, c1, c2, c3, c4, c5;
  logic signed [63:0] dtv;
  logic signed [63:0] num;
  logic signed [63:0] sh;
  logic [DivW-1:0]    u_nxt;
  logic               neg_nxt;
  logic [63:0]        hprod, lprod;
  logic [HalfW-1:0]   qh_nxt;
  logic [HalfW+1:0]   qh3;
  logic [1:0]         rh_nxt;
  logic [HalfW-1:0]   ql;
  logic signed [63:0] quo;
  int                 ofs_sh;

  assign dtv = {39'd0, dt};

  always_comb begin
    m0 = '0; m1 = '0; m2 = '0;
    c0 = '0; c1 = '0; c2 = '0; c3 = '0; c4 = '0; c5 = '0;
    num = '0; sh = '0; u_nxt = '0; neg_nxt = 1'b0;
    hprod = '0; lprod = '0; qh_nxt = '0; qh3 = '0; rh_nxt = '0; ql = '0; quo = '0;
    ofs_sh = (cmd.stage == 2'd2) ? FRAC_BITS : FRAC_BITS + 1;
    case (cmd.op)
      OP_D0: begin
        c0 = clamp(64'(q_r[1]) - 64'(q_r[0]));
        m0 = 64'($signed({1'b0, sigma})) * 64'($signed(c0[31:0]));
        c1 = clamp(fshift(m0, FRAC_BITS));
      end
      OP_D1: begin
        m0 = 64'($signed({1'b0, rho})) * 64'(q_r[0]);
        m1 = 64'(q_r[0]) * 64'(q_r[2]);
        c1 = clamp(fshift(m0, FRAC_BITS));
        c2 = clamp(fshift(m1, FRAC_BITS));
      end
      OP_D2: begin
        c1 = clamp(64'(t_r[0]) - 64'(q_r[1]));
        c2 = clamp(64'($signed(c1[31:0])) - 64'(t_r[1]));
      end
      OP_D3: begin
        m0 = 64'(q_r[0]) * 64'(q_r[1]);
        m1 = 64'($signed({1'b0, beta})) * 64'(q_r[2]);
        c1 = clamp(fshift(m0, FRAC_BITS));
        c2 = clamp(fshift(m1, FRAC_BITS));
      end
      OP_D4: begin
        c1 = clamp(64'(t_r[2]) - 64'(t_r[3]));
      end
      OP_OFS: begin
        m0 = 64'(k_r[0]) * dtv;
        m1 = 64'(k_r[1]) * dtv;
        m2 = 64'(k_r[2]) * dtv;
        c0 = clamp(fshift(m0, ofs_sh));
        c1 = clamp(fshift(m1, ofs_sh));
        c2 = clamp(fshift(m2, ofs_sh));
        c3 = clamp(64'(p_r[0]) + 64'($signed(c0[31:0])));
        c4 = clamp(64'(p_r[1]) + 64'($signed(c1[31:0])));
        c5 = clamp(64'(p_r[2]) + 64'($signed(c2[31:0])));
      end
      OP_FIN0: begin
        // Floor by 2^(FRAC_BITS+1) here, the remaining floor by 3 follows.
        num = 64'(acc_r[cmd.stage]) * dtv;
        sh = num >>> (FRAC_BITS + 1);
        neg_nxt = sh[63];
        // A negative value is floored through the magnitude plus two.
        u_nxt = neg_nxt ? DivW'(64'sd2 - sh) : DivW'(sh);
      end
      OP_FIN1: begin
        hprod = 64'(u_r[DivW-1:HalfW]) * RECIP3;
        qh_nxt = HalfW'(hprod >> 33);
        qh3 = {1'b0, qh_nxt, 1'b0} + {2'b00, qh_nxt};
        rh_nxt = 2'({2'b00, u_r[DivW-1:HalfW]} - qh3);
      end
      OP_FIN2: begin
        lprod = 64'({rh_r, u_r[HalfW-1:0]}) * RECIP3;
        ql = HalfW'(lprod >> 33);
        quo = $signed({20'd0, qh_r, ql});
        if (neg_r) quo = -quo;
        c1 = clamp(quo);
        c2 = clamp(64'(p_r[cmd.stage]) + 64'($signed(c1[31:0])));
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r <= '{default: '0};
      sat_r <= 1'b0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          p_r[0] <= item.start_x; p_r[1] <= item.start_y; p_r[2] <= item.start_z;
          sat_r <= 1'b0;
        end
        OP_INIT: begin
          q_r <= p_r;
          for (int i = 0; i < 3; i++) acc_r[i] <= '0;
          sat_r <= 1'b0;
        end
        OP_D0: begin
          k_r[0] <= c1[31:0];
          sat_r <= sat_r | c0[32] | c1[32];
        end
        OP_D1: begin
          t_r[0] <= c1[31:0]; t_r[1] <= c2[31:0];
          sat_r <= sat_r | c1[32] | c2[32];
        end
        OP_D2: begin
          k_r[1] <= c2[31:0];
          sat_r <= sat_r | c1[32] | c2[32];
        end
        OP_D3: begin
          t_r[2] <= c1[31:0]; t_r[3] <= c2[31:0];
          sat_r <= sat_r | c1[32] | c2[32];
        end
        OP_D4: begin
          k_r[2] <= c1[31:0];
          sat_r <= sat_r | c1[32];
        end
        OP_ACC: begin
          for (int i = 0; i < 3; i++) begin
            if (cmd.stage == 2'd0 || cmd.stage == 2'd3) acc_r[i] <= acc_r[i] + 35'(k_r[i]);
            else acc_r[i] <= acc_r[i] + (35'(k_r[i]) <<< 1);
          end
        end
        OP_OFS: begin
          q_r[0] <= c3[31:0]; q_r[1] <= c4[31:0]; q_r[2] <= c5[31:0];
          sat_r <= sat_r | c0[32] | c1[32] | c2[32] | c3[32] | c4[32] | c5[32];
        end
        OP_FIN0: begin
          u_r <= u_nxt;
          neg_r <= neg_nxt;
        end
        OP_FIN1: begin
          qh_r <= qh_nxt;
          rh_r <= rh_nxt;
        end
        OP_FIN2: begin
          p_r[cmd.stage] <= c2[31:0];
          sat_r <= sat_r | c1[32] | c2[32];
        end
        default: ;
      endcase
    end
  end

  assign result = '{pos_x: p_r[0], pos_y: p_r[1], pos_z: p_r[2], saturated: sat_r};

endmodule

### src/lrk4_ctrl.sv
// Sequencer of the Lorenz RK4 integrator: handshake and datapath commands.
// Uses lrk4_pkg.
module lrk4_ctrl
  import lrk4_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  logic    in_cmd,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  output dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_INIT, S_D0, S_D1, S_D2, S_D3, S_D4, S_ACC, S_OFS,
    S_F0, S_F1, S_F2, S_OUT
  } state_t;

  state_t     state_r;
  logic [1:0] stage_r;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    cmd.stage = stage_r;
    case (state_r)
      // A load takes the point at the accepting edge, while the payload is still driven.
      S_IDLE: cmd.op = (in_valid && in_cmd == CMD_LOAD) ? OP_LOAD : OP_NONE;
      S_INIT: cmd.op = OP_INIT;
      S_D0:   cmd.op = OP_D0;
      S_D1:   cmd.op = OP_D1;
      S_D2:   cmd.op = OP_D2;
      S_D3:   cmd.op = OP_D3;
      S_D4:   cmd.op = OP_D4;
      S_ACC:  cmd.op = OP_ACC;
      S_OFS:  cmd.op = OP_OFS;
      S_F0:   cmd.op = OP_FIN0;
      S_F1:   cmd.op = OP_FIN1;
      S_F2:   cmd.op = OP_FIN2;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stage_r <= '0;
    end else begin
      case (state_r)
        S_IDLE: if (in_valid) state_r <= (in_cmd == CMD_STEP) ? S_INIT : S_OUT;
        S_INIT: begin
          stage_r <= '0;
          state_r <= S_D0;
        end
        S_D0: state_r <= S_D1;
        S_D1: state_r <= S_D2;
        S_D2: state_r <= S_D3;
        S_D3: state_r <= S_D4;
        S_D4: state_r <= S_ACC;
        S_ACC: begin
          if (stage_r == 2'd3) begin
            stage_r <= '0;
            state_r <= S_F0;
          end else begin
            state_r <= S_OFS;
          end
        end
        S_OFS: begin
          stage_r <= stage_r + 2'd1;
          state_r <= S_D0;
        end
        S_F0: state_r <= S_F1;
        S_F1: state_r <= S_F2;
        S_F2: begin
          if (stage_r == 2'd2) begin
            state_r <= S_OUT;
          end else begin
            stage_r <= stage_r + 2'd1;
            state_r <= S_F0;
          end
        end
        S_OUT: if (!out_stall) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### dv/tb_lorenz_rk4_integrator.sv
// Self-checking testbench for lorenz_rk4_integrator: directed table, then random
// phases under several register settings, checked against a fixed-point RK4 predictor.
// Depends on lrk4_pkg and the RTL of the integrator only.
`timescale 1ns / 100ps

module tb_lorenz_rk4_integrator;
  import lrk4_pkg::*;

  localparam int FB = FracBitsDef;
  localparam int IDLE_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 150;

  typedef longint sl;

  typedef struct {
    in_item_t  item;
    bit        has_exp;
    out_item_t exp;
  } stim_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_item;
  logic      cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_data;

  // Predictor state: current point and register copies.
  sl  pt[3];
  sl  sig_r, rho_r, beta_r, dt_r;
  bit clamped;

  out_item_t point_q[$];
  int  errors;
  int  n_sent, n_recv, n_sat;
  bit  no_idle;
  bit  hold_req;
  int  hold_left, wait_left, idle_cycles;
  stim_row_t dir_rows[$];

  lorenz_rk4_integrator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic sl sat32(sl v);
    if (v > 64'sd2147483647) begin
      clamped = 1'b1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      clamped = 1'b1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic sl qmul(sl a, sl b);
    return sat32((a * b) >>> FB);
  endfunction

  function automatic void lorenz_slope(input sl p[3], output sl d[3]);
    d[0] = qmul(sig_r, sat32(p[1] - p[0]));
    d[1] = sat32(sat32(qmul(rho_r, p[0]) - p[1]) - qmul(p[0], p[2]));
    d[2] = sat32(qmul(p[0], p[1]) - qmul(beta_r, p[2]));
  endfunction

  function automatic void advance(input sl p[3], input sl k[3], input int sh, output sl q[3]);
    for (int i = 0; i < 3; i++) q[i] = sat32(p[i] + sat32((k[i] * dt_r) >>> sh));
  endfunction

  // Applies one transaction to the predicted point and returns the expected result.
  function automatic out_item_t integrate(in_item_t it);
    sl k1[3], k2[3], k3[3], k4[3], q[3];
    sl sum, v, inc, den;
    out_item_t r;
    den = sl'(6) << FB;
    clamped = 1'b0;
    if (it.cmd == CMD_LOAD) begin
      pt[0] = it.start_x;
      pt[1] = it.start_y;
      pt[2] = it.start_z;
    end else begin
      lorenz_slope(pt, k1);
      advance(pt, k1, FB + 1, q);
      lorenz_slope(q, k2);
      advance(pt, k2, FB + 1, q);
      lorenz_slope(q, k3);
      advance(pt, k3, FB, q);
      lorenz_slope(q, k4);
      for (int i = 0; i < 3; i++) begin
        sum = k1[i] + 2 * k2[i] + 2 * k3[i] + k4[i];
        v = sum * dt_r;
        if (v >= 0) inc = v / den;
        else inc = -((-v + den - 1) / den);
        pt[i] = sat32(pt[i] + sat32(inc));
      end
    end
    r.pos_x = pt[0][31:0];
    r.pos_y = pt[1][31:0];
    r.pos_z = pt[2][31:0];
    r.saturated = clamped;
    return r;
  endfunction

  function automatic in_item_t mk_item(logic c, logic [31:0] x, logic [31:0] y,
                                       logic [31:0] z);
    in_item_t it;
    it.cmd = c;
    it.start_x = x;
    it.start_y = y;
    it.start_z = z;
    return it;
  endfunction

  function automatic void add_row(in_item_t it, bit has_exp, logic [31:0] x,
                                  logic [31:0] y, logic [31:0] z, logic s);
    stim_row_t r;
    r.item = it;
    r.has_exp = has_exp;
    r.exp.pos_x = x;
    r.exp.pos_y = y;
    r.exp.pos_z = z;
    r.exp.saturated = s;
    dir_rows.insert(dir_rows.size(), r);
  endfunction

  // Drives one transaction, waits for acceptance and records the expectation.
  task automatic send(in_item_t it, bit has_exp = 1'b0, out_item_t fixed = '0);
    int gap;
    out_item_t pred;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (in_stall);
    pred = integrate(it);
    if (has_exp && pred != fixed) begin
      $display("%0t: table row disagrees with predictor: exp %h pred %h", $time, fixed, pred);
      errors++;
    end
    point_q.insert(point_q.size(), has_exp ? fixed : pred);
    n_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (point_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgW-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    case (idx)
      REG_SIGMA: sig_r = sl'(val);
      REG_RHO:   rho_r = sl'(val);
      REG_BETA:  beta_r = sl'(val);
      default:   dt_r = sl'(val[DtW-1:0]);
    endcase
  endtask

  task automatic set_regs(logic [CfgW-1:0] s, logic [CfgW-1:0] r, logic [CfgW-1:0] b,
                          logic [CfgW-1:0] d);
    drain();
    write_reg(REG_SIGMA, s);
    write_reg(REG_RHO, r);
    write_reg(REG_BETA, b);
    write_reg(REG_DT, d);
    cfg_we <= 1'b0;
  endtask

  // Mostly a load near the attractor followed by a run of steps; some raw noise.
  task automatic random_phase(int count);
    int left, run;
    left = count;
    while (left > 0) begin
      if ($urandom_range(0, 9) < 2) begin
        send(mk_item($urandom_range(0, 1), $urandom, $urandom, $urandom));
        left--;
      end else begin
        send(mk_item(CMD_LOAD, $signed($urandom_range(0, 60 << FB)) - (30 << FB),
                     $signed($urandom_range(0, 60 << FB)) - (30 << FB),
                     $urandom_range(0, 50 << FB)));
        run = $urandom_range(1, 12);
        for (int i = 0; i < run && left > 0; i++) begin
          send(mk_item(CMD_STEP, $urandom, $urandom, $urandom));
          left--;
        end
        left--;
      end
    end
  endtask

  // Receiver: random stall per result, plus an optional long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left <= 0;
      wait_left <= 0;
    end else if (hold_req && hold_left == 0) begin
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1);
    end else if (out_valid && !out_stall) begin
      wait_left <= no_idle ? 0 : $urandom_range(0, 4);
      out_stall <= !no_idle && ($urandom_range(0, 1) == 1);
    end else if (wait_left > 0) begin
      wait_left <= wait_left - 1;
      out_stall <= (wait_left > 1);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker and watchdog.
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
      if (out_valid && !out_stall) begin
        n_recv++;
        if (point_q.size() == 0) begin
          $display("%0t: unexpected transaction %h", $time, out_item);
          errors++;
        end else begin
          e = point_q.pop_front();
          if (out_item.saturated) n_sat++;
          if (out_item.pos_x !== e.pos_x) begin
            $display("%0t: pos_x exp %h got %h", $time, e.pos_x, out_item.pos_x);
            errors++;
          end
          if (out_item.pos_y !== e.pos_y) begin
            $display("%0t: pos_y exp %h got %h", $time, e.pos_y, out_item.pos_y);
            errors++;
          end
          if (out_item.pos_z !== e.pos_z) begin
            $display("%0t: pos_z exp %h got %h", $time, e.pos_z, out_item.pos_z);
            errors++;
          end
          if (out_item.saturated !== e.saturated) begin
            $display("%0t: saturated exp %b got %b", $time, e.saturated,
                     out_item.saturated);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_item <= '0;
    cfg_we <= 1'b0;
    cfg_index <= REG_SIGMA;
    cfg_data <= '0;
    hold_req = 1'b0;
    no_idle = 1'b0;
    errors = 0;
    n_sent = 0;
    n_recv = 0;
    n_sat = 0;
    idle_cycles = 0;
    pt = '{0, 0, 0};
    sig_r = 167772160;
    rho_r = 469762048;
    beta_r = 44739243;
    dt_r = 83886;

    // A step from the reset origin stays at the origin; loads echo the point.
    add_row(mk_item(CMD_STEP, '1, '1, '1), 1, 0, 0, 0, 0);
    add_row(mk_item(CMD_LOAD, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF), 1,
            32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0);
    add_row(mk_item(CMD_STEP, 0, 0, 0), 0, 0, 0, 0, 0);
    add_row(mk_item(CMD_LOAD, 32'h80000000, 32'h7FFFFFFF, 32'h80000000), 1,
            32'h80000000, 32'h7FFFFFFF, 32'h80000000, 0);
    add_row(mk_item(CMD_STEP, 0, 0, 0), 0, 0, 0, 0, 0);
    add_row(mk_item(CMD_LOAD, 0, 0, 0), 1, 0, 0, 0, 0);
    add_row(mk_item(CMD_STEP, 0, 0, 0), 1, 0, 0, 0, 0);
    add_row(mk_item(CMD_LOAD, 32'hFFFFFFFF, 32'h00000001, 32'hFFFFFFFF), 1,
            32'hFFFFFFFF, 32'h00000001, 32'hFFFFFFFF, 0);
    add_row(mk_item(CMD_STEP, 0, 0, 0), 0, 0, 0, 0, 0);
    add_row(mk_item(CMD_LOAD, 1 << FB, 1 << FB, 1 << FB), 1,
            1 << FB, 1 << FB, 1 << FB, 0);
    for (int i = 0; i < 4; i++) add_row(mk_item(CMD_STEP, 0, 0, 0), 0, 0, 0, 0, 0);
    add_row(mk_item(CMD_LOAD, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000), 1,
            32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 0);
    add_row(mk_item(CMD_STEP, 0, 0, 0), 0, 0, 0, 0, 0);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) send(dir_rows[i].item, dir_rows[i].has_exp, dir_rows[i].exp);

    // Defaults, with a long receiver hold-off while items keep coming.
    random_phase(PHASE_ITEMS / 2);
    hold_req = 1'b1;
    no_idle = 1'b1;
    for (int i = 0; i < 8; i++) send(mk_item(CMD_STEP, 0, 0, 0));
    hold_req = 1'b0;
    no_idle = 1'b0;
    in_valid <= 1'b0;
    while (point_q.size() != 0) @(posedge clk);
    random_phase(PHASE_ITEMS / 2);

    // Zero time step and zero coefficients: the point must not move.
    set_regs(0, 0, 0, 0);
    send(mk_item(CMD_LOAD, 32'h12345678, 32'h87654321, 32'h7FFFFFFF));
    for (int i = 0; i < 3; i++) send(mk_item(CMD_STEP, 0, 0, 0));
    random_phase(PHASE_ITEMS / 2);

    // Coefficient registers at their top, with a unit time step.
    set_regs('1, '1, '1, 1 << FB);
    random_phase(PHASE_ITEMS / 2);

    // Smallest nonzero time step.
    set_regs(1, 1, 1, 1);
    random_phase(PHASE_ITEMS / 2);

    // Fully random register values, several times, with a run without idling.
    for (int ph = 0; ph < 3; ph++) begin
      set_regs($urandom, $urandom, $urandom, $urandom);
      no_idle = (ph == 1);
      random_phase(PHASE_ITEMS / 2);
    end
    no_idle = 1'b0;

    set_regs(167772160, 469762048, 44739243, 83886);
    random_phase(PHASE_ITEMS);

    drain();
    $display("Covered %0d transactions in, %0d out (%0d saturated) over eight settings.",
             n_sent, n_recv, n_sat);
    if (errors == 0 && point_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### lorenz_rk4_integrator.f
src/lrk4_pkg.sv
src/lrk4_datapath.sv
src/lrk4_ctrl.sv
src/lorenz_rk4_integrator.sv
dv/tb_lorenz_rk4_integrator.sv
